@@ hw/rtl/iptt_pkg.sv @@
`default_nettype none

package iptt_pkg;

   localparam int MODE_W         = 2;
   localparam int TASK_ID_W      = 8;
   localparam int USER_ID_W      = 16;
   localparam int PRIORITY_REQ_W = 32;
   localparam int OWNER_ID_W     = 16;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EDIT   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_EXEC   = 2'd3;

   typedef struct packed {
      logic clr_step;
      logic acc_add;
      logic acc_remove;
      logic acc_edit;
      logic edit_commit;
      logic scan_start;
      logic scan_issue;
      logic top_take;
      logic rsp_load_empty;
      logic rsp_load_owner;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic in_range;
      logic edit_hit;
      logic found;
   } status_type;

endpackage

`default_nettype wire

@@ hw/rtl/iptt_ctrl.sv @@
`default_nettype none

module iptt_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [iptt_pkg::MODE_W-1:0]       req_mode,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire iptt_pkg::status_type              status,
   output iptt_pkg::cmd_type                      cmd
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EDIT   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_DECIDE = 3'd5;
   localparam logic [2:0] S_OWNER  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;
   logic       out_free;

   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.idx_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  iptt_pkg::MODE_ADD: begin
                     cmd.acc_add = status.in_range;
                  end
                  iptt_pkg::MODE_REMOVE: begin
                     cmd.acc_remove = status.in_range;
                  end
                  iptt_pkg::MODE_EDIT: begin
                     if (status.in_range) begin
                        cmd.acc_edit = 1'b1;
                        state_in     = S_EDIT;
                     end
                  end
                  iptt_pkg::MODE_EXEC: begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               endcase
            end
         end
         S_EDIT: begin
            cmd.edit_commit = status.edit_hit;
            state_in        = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.idx_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.found) begin
               cmd.top_take = 1'b1;
               state_in     = S_OWNER;
            end else if (out_free) begin
               cmd.rsp_load_empty = 1'b1;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         S_OWNER: begin
            if (out_free) begin
               cmd.rsp_load_owner = 1'b1;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_exec_scans: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == iptt_pkg::MODE_EXEC) |=> state_ff == S_SCAN)
      else $error("execute transaction did not start a scan");

   a_edit_checks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_mode == iptt_pkg::MODE_EDIT && status.in_range)
      |=> state_ff == S_EDIT)
      else $error("edit transaction did not check entry");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DECIDE || $past(state_ff) == S_OWNER))
      else $error("response raised outside result states");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> (!rsp_valid_ff && !cmd.acc_add && !cmd.scan_issue))
      else $error("activity during clearing pass");

endmodule

`default_nettype wire

@@ hw/rtl/iptt_dp.sv @@
`default_nettype none

module iptt_dp #(
   parameter int TASK_SLOTS    = 256,
   parameter int PRIORITY_BITS = 32,
   parameter int USER_BITS     = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire iptt_pkg::cmd_type                   cmd,
   output iptt_pkg::status_type                     status,
   input  wire logic [iptt_pkg::TASK_ID_W-1:0]      req_task_id,
   input  wire logic [iptt_pkg::USER_ID_W-1:0]      req_user_id,
   input  wire logic [iptt_pkg::PRIORITY_REQ_W-1:0] req_priority_req,
   output logic [iptt_pkg::OWNER_ID_W-1:0]          rsp_owner_id,
   output logic                                     rsp_table_empty
);

   localparam int SLOT_W = $clog2(TASK_SLOTS);
   localparam int ID_W   = (SLOT_W > iptt_pkg::TASK_ID_W) ? SLOT_W : iptt_pkg::TASK_ID_W;
   localparam int UIN_W  = (USER_BITS > iptt_pkg::USER_ID_W) ? USER_BITS
                                                            : iptt_pkg::USER_ID_W;
   localparam int UOUT_W = (USER_BITS > iptt_pkg::OWNER_ID_W) ? USER_BITS
                                                             : iptt_pkg::OWNER_ID_W;
   localparam int PIN_W  = (PRIORITY_BITS > iptt_pkg::PRIORITY_REQ_W) ? PRIORITY_BITS
                                                                     : iptt_pkg::PRIORITY_REQ_W;
   localparam int ENT_W  = PRIORITY_BITS + 1;

   logic [ID_W-1:0]          id_wide;
   logic [SLOT_W-1:0]        slot;
   logic [UIN_W-1:0]         user_wide;
   logic [USER_BITS-1:0]     user_in;
   logic [PIN_W-1:0]         prio_wide;
   logic [PRIORITY_BITS-1:0] prio_in;
   logic [UOUT_W-1:0]        owner_wide;

   logic [ENT_W-1:0]         ent_mem [TASK_SLOTS];
   logic [USER_BITS-1:0]     own_mem [TASK_SLOTS];
   logic [ENT_W-1:0]         ent_rd_ff;
   logic [USER_BITS-1:0]     own_rd_ff;

   logic                     ent_we;
   logic [SLOT_W-1:0]        ent_waddr;
   logic [ENT_W-1:0]         ent_wdata;
   logic                     ent_re;
   logic [SLOT_W-1:0]        ent_raddr;

   logic [SLOT_W-1:0]        idx_ff, idx_in;
   logic                     idx_last;
   logic                     cmp_live_ff;
   logic [SLOT_W-1:0]        cmp_idx_ff;
   logic                     found_ff, found_in;
   logic [SLOT_W-1:0]        best_idx_ff;
   logic [PRIORITY_BITS-1:0] best_prio_ff;
   logic                     take;
   logic [SLOT_W-1:0]        edit_slot_ff;
   logic [PRIORITY_BITS-1:0] edit_prio_ff;

   assign id_wide   = ID_W'(req_task_id);
   assign slot      = id_wide[SLOT_W-1:0];
   assign user_wide = UIN_W'(req_user_id);
   assign user_in   = user_wide[USER_BITS-1:0];
   assign prio_wide = PIN_W'(req_priority_req);
   assign prio_in   = prio_wide[PRIORITY_BITS-1:0];
   assign owner_wide = UOUT_W'(own_rd_ff);

   assign idx_last = (idx_ff == SLOT_W'(TASK_SLOTS - 1));

   assign status.idx_last = idx_last;
   assign status.in_range = ({1'b0, id_wide} < (ID_W + 1)'(TASK_SLOTS));
   assign status.edit_hit = ent_rd_ff[PRIORITY_BITS];
   assign status.found    = found_ff;

   assign take = cmp_live_ff && ent_rd_ff[PRIORITY_BITS]
              && (!found_ff || (ent_rd_ff[PRIORITY_BITS-1:0] >= best_prio_ff));

   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.clr_step || cmd.scan_issue) begin
         idx_in = idx_last ? '0 : idx_ff + SLOT_W'(1);
      end
   end

   always_comb begin
      found_in = found_ff;
      if (cmd.scan_start) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   always_comb begin
      ent_we    = 1'b0;
      ent_waddr = slot;
      ent_wdata = {1'b0, prio_in};
      if (cmd.clr_step) begin
         ent_we    = 1'b1;
         ent_waddr = idx_ff;
         ent_wdata = '0;
      end else if (cmd.acc_add) begin
         ent_we    = 1'b1;
         ent_wdata = {1'b1, prio_in};
      end else if (cmd.acc_remove) begin
         ent_we    = 1'b1;
      end else if (cmd.edit_commit) begin
         ent_we    = 1'b1;
         ent_waddr = edit_slot_ff;
         ent_wdata = {1'b1, edit_prio_ff};
      end else if (cmd.top_take) begin
         ent_we    = 1'b1;
         ent_waddr = best_idx_ff;
         ent_wdata = '0;
      end
   end

   assign ent_re    = cmd.acc_edit || cmd.scan_issue;
   assign ent_raddr = cmd.scan_issue ? idx_ff : slot;

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      if (ent_re) begin
         ent_rd_ff <= ent_mem[ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_add) begin
         own_mem[slot] <= user_in;
      end
      if (cmd.top_take) begin
         own_rd_ff <= own_mem[best_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         cmp_live_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         cmp_live_ff <= cmd.scan_issue;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= idx_ff;
      if (take) begin
         best_idx_ff  <= cmp_idx_ff;
         best_prio_ff <= ent_rd_ff[PRIORITY_BITS-1:0];
      end
      if (cmd.acc_edit) begin
         edit_slot_ff <= slot;
         edit_prio_ff <= prio_in;
      end
      if (cmd.rsp_load_empty) begin
         rsp_owner_id    <= '0;
         rsp_table_empty <= 1'b1;
      end else if (cmd.rsp_load_owner) begin
         rsp_owner_id    <= owner_wide[iptt_pkg::OWNER_ID_W-1:0];
         rsp_table_empty <= 1'b0;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/indexed_priority_task_table.sv @@
// add and remove write on accept; edit commits in S_EDIT before the next request is taken
// execute top scans the entry memory one slot per cycle through its single read port:
// S_DRAIN and S_DECIDE follow; the empty result is registered in S_DECIDE, an owner in S_OWNER,
// each only once the output is free; req_stall stays high until the controller is back in S_IDLE
// reset: synchronous, then a clearing pass over all TASK_SLOTS entries with req_stall high
`default_nettype none

module indexed_priority_task_table #(
   parameter int TASK_SLOTS    = 256,
   parameter int PRIORITY_BITS = 32,
   parameter int USER_BITS     = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [iptt_pkg::MODE_W-1:0]         req_mode,
   input  wire logic [iptt_pkg::TASK_ID_W-1:0]      req_task_id,
   input  wire logic [iptt_pkg::USER_ID_W-1:0]      req_user_id,
   input  wire logic [iptt_pkg::PRIORITY_REQ_W-1:0] req_priority_req,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [iptt_pkg::OWNER_ID_W-1:0]          rsp_owner_id,
   output logic                                     rsp_table_empty
);

   iptt_pkg::cmd_type    cmd;
   iptt_pkg::status_type status;

   iptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   iptt_dp #(
      .TASK_SLOTS    (TASK_SLOTS),
      .PRIORITY_BITS (PRIORITY_BITS),
      .USER_BITS     (USER_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_task_id      (req_task_id),
      .req_user_id      (req_user_id),
      .req_priority_req (req_priority_req),
      .rsp_owner_id     (rsp_owner_id),
      .rsp_table_empty  (rsp_table_empty)
   );

endmodule

`default_nettype wire

@@ dv/tb_indexed_priority_task_table.sv @@
`default_nettype none

module tb_indexed_priority_task_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TASK_SLOTS   = 256;
   localparam int RANDOM_ITEMS = 1825;
   localparam int DRAIN_CYCLES = TASK_SLOTS + 40;

   typedef struct packed {
      logic [iptt_pkg::OWNER_ID_W-1:0] owner_id;
      logic                            table_empty;
   } top_type;

   typedef struct {
      logic [iptt_pkg::MODE_W-1:0]         mode;
      logic [iptt_pkg::TASK_ID_W-1:0]      task_id;
      logic [iptt_pkg::USER_ID_W-1:0]      user_id;
      logic [iptt_pkg::PRIORITY_REQ_W-1:0] prio;
      bit                                  typed;
      top_type                             top;
   } op_type;

   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_valid        = 1'b0;
   logic                                req_stall;
   logic [iptt_pkg::MODE_W-1:0]         req_mode         = iptt_pkg::MODE_ADD;
   logic [iptt_pkg::TASK_ID_W-1:0]      req_task_id      = '0;
   logic [iptt_pkg::USER_ID_W-1:0]      req_user_id      = '0;
   logic [iptt_pkg::PRIORITY_REQ_W-1:0] req_priority_req = '0;
   logic                                rsp_valid;
   logic                                rsp_stall        = 1'b0;
   logic [iptt_pkg::OWNER_ID_W-1:0]     rsp_owner_id;
   logic                                rsp_table_empty;

   // task table mirror
   bit                                  slot_valid [TASK_SLOTS];
   logic [iptt_pkg::USER_ID_W-1:0]      slot_owner [TASK_SLOTS];
   logic [iptt_pkg::PRIORITY_REQ_W-1:0] slot_prio  [TASK_SLOTS];

   top_type pending_tops [$];
   op_type  directed_ops [$];
   int      mismatch_count = 0;
   int      burst_left     = 0;
   int      stall_left     = 0;
   int      stall_kind     = 0;

   indexed_priority_task_table i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_task_id      (req_task_id),
      .req_user_id      (req_user_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_owner_id     (rsp_owner_id),
      .rsp_table_empty  (rsp_table_empty)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #25ms;
      $display("FAIL indexed_priority_task_table");
      $finish;
   end

   function automatic op_type plain_op(input logic [iptt_pkg::MODE_W-1:0] mode,
                                       input logic [iptt_pkg::TASK_ID_W-1:0] task_id,
                                       input logic [iptt_pkg::USER_ID_W-1:0] user_id,
                                       input logic [iptt_pkg::PRIORITY_REQ_W-1:0] prio);
      op_type op;
      op.mode    = mode;
      op.task_id = task_id;
      op.user_id = user_id;
      op.prio    = prio;
      op.typed   = 1'b0;
      op.top     = '0;
      return op;
   endfunction

   function automatic op_type exec_op(input logic [iptt_pkg::OWNER_ID_W-1:0] owner_id,
                                      input logic table_empty);
      op_type op;
      op             = plain_op(iptt_pkg::MODE_EXEC, '0, '0, '0);
      op.typed       = 1'b1;
      op.top.owner_id    = owner_id;
      op.top.table_empty = table_empty;
      return op;
   endfunction

   function automatic void table_row(input op_type op);
      directed_ops.insert(directed_ops.size(), op);
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch %s: expected %0h, got %0h", what, want, got);
      end
   endtask

   task automatic update_task_table(input op_type op, output bit has_top,
                                    output top_type top);
      int best;
      bit found;
      has_top   = 1'b0;
      top       = '0;
      case (op.mode)
         iptt_pkg::MODE_ADD: begin
            slot_valid[op.task_id] = 1'b1;
            slot_owner[op.task_id] = op.user_id;
            slot_prio[op.task_id]  = op.prio;
         end
         iptt_pkg::MODE_EDIT: begin
            if (slot_valid[op.task_id]) slot_prio[op.task_id] = op.prio;
         end
         iptt_pkg::MODE_REMOVE: begin
            slot_valid[op.task_id] = 1'b0;
         end
         default: begin
            found = 1'b0;
            best  = 0;
            // ascending scan, ties go to the higher id
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (slot_valid[i] && (!found || slot_prio[i] >= slot_prio[best])) begin
                  found = 1'b1;
                  best  = i;
               end
            end
            has_top = 1'b1;
            if (found) begin
               top.owner_id     = slot_owner[best];
               top.table_empty  = 1'b0;
               slot_valid[best] = 1'b0;
            end else begin
               top.table_empty = 1'b1;
            end
         end
      endcase
   endtask

   task automatic make_random_op(input int phase, output op_type op);
      int roll;
      int t_add;
      int t_edit;
      int t_rem;
      int id;
      int present_ids [$];
      case (phase)
         0: begin t_add = 60; t_edit = 75; t_rem = 85; end
         1: begin t_add = 10; t_edit = 20; t_rem = 30; end
         default: begin t_add = 30; t_edit = 50; t_rem = 65; end
      endcase
      op   = plain_op(iptt_pkg::MODE_ADD, '0, '0, '0);
      roll = $urandom_range(0, 99);
      if (roll < t_add) op.mode = iptt_pkg::MODE_ADD;
      else if (roll < t_edit) op.mode = iptt_pkg::MODE_EDIT;
      else if (roll < t_rem) op.mode = iptt_pkg::MODE_REMOVE;
      else op.mode = iptt_pkg::MODE_EXEC;

      id = $urandom_range(0, TASK_SLOTS - 1);
      case ($urandom_range(0, 5))
         0, 1: begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
               if (slot_valid[i]) present_ids.insert(present_ids.size(), i);
            end
            if (present_ids.size() > 0) begin
               id = present_ids[$urandom_range(0, present_ids.size() - 1)];
            end
         end
         2: id = $urandom_range(0, 7);
         3: id = $urandom_range(TASK_SLOTS - 8, TASK_SLOTS - 1);
         default: ;
      endcase
      op.task_id = iptt_pkg::TASK_ID_W'(id);

      case ($urandom_range(0, 7))
         0: op.user_id = '0;
         1: op.user_id = '1;
         default: op.user_id = iptt_pkg::USER_ID_W'($urandom_range(0, 65535));
      endcase

      // small values crowd the ties
      case ($urandom_range(0, 9))
         0: op.prio = '0;
         1: op.prio = '1;
         2, 3: op.prio = $urandom_range(0, 3);
         4: op.prio = 32'hffff_fffc | $urandom_range(0, 3);
         default: op.prio = $urandom();
      endcase
   endtask

   task automatic send_op(input op_type op);
      bit      has_top;
      top_type top;
      req_mode         = op.mode;
      req_task_id      = op.task_id;
      req_user_id      = op.user_id;
      req_priority_req = op.prio;
      req_valid        = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      update_task_table(op, has_top, top);
      if (has_top) pending_tops.insert(pending_tops.size(), op.typed ? op.top : top);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_left <= 0) begin
         stall_kind = $urandom_range(0, 3);
         stall_left = $urandom_range(8, 64);
      end
      stall_left--;
      case (stall_kind)
         0, 1: rsp_stall = 1'b0;
         2: rsp_stall = ($urandom_range(0, 1) == 1);
         default: rsp_stall = 1'b1;
      endcase
   end

   always @(posedge clock) begin : rsp_check
      top_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_tops.size() == 0) begin
            flag_mismatch("unexpected transaction, owner_id", '0, 32'(rsp_owner_id));
         end else begin
            want = pending_tops.pop_front();
            if (rsp_owner_id !== want.owner_id) begin
               flag_mismatch("owner_id", 32'(want.owner_id), 32'(rsp_owner_id));
            end
            if (rsp_table_empty !== want.table_empty) begin
               flag_mismatch("table_empty", 32'(want.table_empty), 32'(rsp_table_empty));
            end
         end
      end
   end

   initial begin
      op_type op;
      int     random_items;

      for (int i = 0; i < TASK_SLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_owner[i] = '0;
         slot_prio[i]  = '0;
      end

      table_row(exec_op(16'h0000, 1'b1));
      table_row(plain_op(iptt_pkg::MODE_EDIT, 8'd5, 16'h1111, 32'd9));
      table_row(plain_op(iptt_pkg::MODE_REMOVE, 8'd7, 16'h0000, 32'd0));
      table_row(plain_op(iptt_pkg::MODE_ADD, 8'd0, 16'h0000, 32'h0000_0000));
      table_row(exec_op(16'h0000, 1'b0));
      table_row(exec_op(16'h0000, 1'b1));
      table_row(plain_op(iptt_pkg::MODE_ADD, 8'd255, 16'hffff, 32'hffff_ffff));
      table_row(plain_op(iptt_pkg::MODE_ADD, 8'd0, 16'h1234, 32'hffff_ffff));
      table_row(exec_op(16'hffff, 1'b0));
      table_row(exec_op(16'h1234, 1'b0));
      table_row(exec_op(16'h0000, 1'b1));
      table_row(plain_op(iptt_pkg::MODE_ADD, 8'd10, 16'haaaa, 32'd5));
      table_row(plain_op(iptt_pkg::MODE_ADD, 8'd10, 16'h5555, 32'd7));
      table_row(plain_op(iptt_pkg::MODE_ADD, 8'd20, 16'h0001, 32'd6));
      table_row(exec_op(16'h5555, 1'b0));
      table_row(exec_op(16'h0001, 1'b0));
      table_row(plain_op(iptt_pkg::MODE_ADD, 8'd30, 16'h0bad, 32'd1));
      table_row(plain_op(iptt_pkg::MODE_EDIT, 8'd30, 16'h0000, 32'hffff_ffff));
      table_row(plain_op(iptt_pkg::MODE_ADD, 8'd31, 16'h0c0f, 32'hffff_fffe));
      table_row(exec_op(16'h0bad, 1'b0));
      table_row(plain_op(iptt_pkg::MODE_ADD, 8'd40, 16'h4444, 32'd100));
      table_row(plain_op(iptt_pkg::MODE_REMOVE, 8'd40, 16'h0000, 32'd0));
      table_row(plain_op(iptt_pkg::MODE_EDIT, 8'd40, 16'h0000, 32'd200));
      table_row(exec_op(16'h0c0f, 1'b0));
      table_row(exec_op(16'h0000, 1'b1));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset      = 1'b0;
      burst_left = $urandom_range(1, 40);

      foreach (directed_ops[i]) send_op(directed_ops[i]);

      // fill, drain and mixed phases so the table both empties and crowds
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         make_random_op((random_items / 60) % 3, op);
         send_op(op);
         random_items++;
      end
      req_valid = 1'b0;

      while (pending_tops.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS indexed_priority_task_table");
      end else begin
         $display("FAIL indexed_priority_task_table");
      end
      $finish;
   end

endmodule

`default_nettype wire
